// ===== rtl/psd_pkg.sv =====
`default_nettype none
// ============================================================================
// psd_pkg
// Shared widths, payload types and stage bus types for the point to segment
// distance pipeline.
// ============================================================================
package psd_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;      // e-s and q-s differences
    localparam int L2_W       = 2 * COORD_BITS + 2;  // squared length, unsigned
    localparam int NUM_W      = 2 * COORD_BITS + 3;  // dot product, signed
    localparam int DIV_W      = 3 * COORD_BITS + 2;  // num * |d| dividend
    localparam int SQ_W       = 2 * COORD_BITS + 1;  // squared distance
    localparam int DIST_W     = COORD_BITS + 1;

    typedef enum logic [1:0] {
        WHERE_INTERIOR = 2'd0,
        WHERE_START    = 2'd1,
        WHERE_END      = 2'd2,
        WHERE_DEGEN    = 2'd3
    } t_where;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic        [DIST_W-1:0]     distance;
        logic        [1:0]            where_code;
    } t_out;

    // Divider stage payload
    typedef struct packed {
        t_in                     pts;
        t_where                  code;
        logic                    neg_x;
        logic                    neg_y;
        logic [L2_W-1:0]         l2;
        logic [DIV_W-1:0]        rem_x;
        logic [DIV_W-1:0]        rem_y;
        logic [COORD_BITS-1:0]   quo_x;
        logic [COORD_BITS-1:0]   quo_y;
    } t_div;

    // Square root stage payload
    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        t_where                       code;
        logic [SQ_W-1:0]              rad;
        logic [DIST_W-1:0]            root;
    } t_sqr;

endpackage
`default_nettype wire

// ===== rtl/psd_div_stage.sv =====
`default_nettype none
// ============================================================================
// psd_div_stage
// One restoring division step for both components: quotient bit K.
// ============================================================================
module psd_div_stage
    import psd_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_div i_data,
    output logic      o_valid,
    output t_div      o_data
);

    logic [DIV_W-1:0] trial;
    t_div             n_data;
    logic             r_valid;
    t_div             r_data;

    always_comb begin
        trial  = DIV_W'(i_data.l2) << K;
        n_data = i_data;
        if (i_data.rem_x >= trial) begin
            n_data.rem_x    = i_data.rem_x - trial;
            n_data.quo_x[K] = 1'b1;
        end
        if (i_data.rem_y >= trial) begin
            n_data.rem_y    = i_data.rem_y - trial;
            n_data.quo_y[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/psd_sqrt_stage.sv =====
`default_nettype none
// ============================================================================
// psd_sqrt_stage
// One digit step of the floor square root: decides root bit K.
// ============================================================================
module psd_sqrt_stage
    import psd_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_sqr i_data,
    output logic      o_valid,
    output t_sqr      o_data
);

    localparam int TW = SQ_W + 1;

    logic [TW-1:0] trial;
    logic [TW-1:0] rad_w;
    t_sqr          n_data;
    logic          r_valid;
    t_sqr          r_data;

    // (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
    always_comb begin
        trial  = (TW'(i_data.root) << (K + 1)) + (TW'(1) << (2 * K));
        rad_w  = TW'(i_data.rad);
        n_data = i_data;
        if (rad_w >= trial) begin
            n_data.rad     = SQ_W'(rad_w - trial);
            n_data.root[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/point_segment_distance.sv =====
`default_nettype none
// ============================================================================
// point_segment_distance
// Closest point on a segment and distance to it, signed Q16.16, pipelined.
// ============================================================================
// Takes one transaction per cycle while not stalled and returns one result per
// transaction in order. The pipeline runs through differences, products and
// split multiply, one quotient bit per stage for the projection divide,
// closest point and squared distance, one root bit per stage for the square
// root, and the output register. The whole pipeline holds while a result
// waits under stall.
module point_segment_distance
    import psd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int N = COORD_BITS;

    logic en;
    logic r_out_valid;
    t_out r_out;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage 1: differences
    logic                     r1_v;
    t_in                      r1_pts;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_qx, r1_qy;

    // ---------------- stage 2: products
    logic                       r2_v;
    t_in                        r2_pts;
    logic signed [DIFF_W-1:0]   r2_dx, r2_dy;
    logic signed [2*DIFF_W-1:0] r2_xx, r2_yy, r2_qdx, r2_qdy;

    // ---------------- stage 3: l2 and num
    logic                     r3_v;
    t_in                      r3_pts;
    logic signed [DIFF_W-1:0] r3_dx, r3_dy;
    logic [L2_W-1:0]          r3_l2;
    logic signed [NUM_W-1:0]  r3_num;

    // ---------------- stage 4: classify, split multiply
    logic              r4_v;
    t_in               r4_pts;
    t_where            r4_code;
    logic              r4_neg_x, r4_neg_y;
    logic [L2_W-1:0]   r4_l2;
    logic [2*N:0]      r4_lo_x, r4_hi_x, r4_lo_y, r4_hi_y;

    t_where            n4_code;
    logic [DIFF_W-1:0] ad_x_w, ad_y_w;
    logic [N-1:0]      ad_x, ad_y;
    logic [L2_W-1:0]   num_u;

    // ---------------- divider chain
    logic div_v [N+1];
    t_div div_d [N+1];
    t_div n5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        ad_x_w  = r3_dx[DIFF_W-1] ? DIFF_W'(-r3_dx) : DIFF_W'(r3_dx);
        ad_y_w  = r3_dy[DIFF_W-1] ? DIFF_W'(-r3_dy) : DIFF_W'(r3_dy);
        ad_x    = ad_x_w[N-1:0];
        ad_y    = ad_y_w[N-1:0];
        num_u   = r3_num[L2_W-1:0];
        if (r3_l2 == '0) begin
            n4_code = WHERE_DEGEN;
        end else if (r3_num[NUM_W-1]) begin
            n4_code = WHERE_START;
        end else if (r3_num[NUM_W-2:0] > r3_l2) begin
            n4_code = WHERE_END;
        end else begin
            n4_code = WHERE_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pts <= i_data;
            r1_dx  <= DIFF_W'(i_data.seg_end_x) - DIFF_W'(i_data.seg_start_x);
            r1_dy  <= DIFF_W'(i_data.seg_end_y) - DIFF_W'(i_data.seg_start_y);
            r1_qx  <= DIFF_W'(i_data.query_x) - DIFF_W'(i_data.seg_start_x);
            r1_qy  <= DIFF_W'(i_data.query_y) - DIFF_W'(i_data.seg_start_y);

            r2_pts <= r1_pts;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_xx  <= r1_dx * r1_dx;
            r2_yy  <= r1_dy * r1_dy;
            r2_qdx <= r1_qx * r1_dx;
            r2_qdy <= r1_qy * r1_dy;

            r3_pts <= r2_pts;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_l2  <= L2_W'($unsigned(r2_xx)) + L2_W'($unsigned(r2_yy));
            r3_num <= NUM_W'(r2_qdx) + NUM_W'(r2_qdy);

            r4_pts   <= r3_pts;
            r4_code  <= n4_code;
            r4_neg_x <= r3_dx[DIFF_W-1];
            r4_neg_y <= r3_dy[DIFF_W-1];
            r4_l2    <= r3_l2;
            r4_lo_x  <= num_u[N:0] * ad_x;
            r4_hi_x  <= num_u[L2_W-1:N+1] * ad_x;
            r4_lo_y  <= num_u[N:0] * ad_y;
            r4_hi_y  <= num_u[L2_W-1:N+1] * ad_y;
        end
    end

    // stage 5: join partial products into the dividend
    always_comb begin
        n5.pts   = r4_pts;
        n5.code  = r4_code;
        n5.neg_x = r4_neg_x;
        n5.neg_y = r4_neg_y;
        n5.l2    = r4_l2;
        n5.rem_x = DIV_W'(r4_lo_x) + (DIV_W'(r4_hi_x) << (N + 1));
        n5.rem_y = DIV_W'(r4_lo_y) + (DIV_W'(r4_hi_y) << (N + 1));
        n5.quo_x = '0;
        n5.quo_y = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_v[0] <= 1'b0;
        end else if (en) begin
            div_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            div_d[0] <= n5;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_div
        psd_div_stage #(
            .K (N - 1 - g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_v[g]),
            .i_data  (div_d[g]),
            .o_valid (div_v[g+1]),
            .o_data  (div_d[g+1])
        );
    end

    // ---------------- closest point and residual
    t_div                     dq;
    logic signed [DIFF_W-1:0] qs_x, qs_y, sum_x, sum_y;
    logic signed [N-1:0]      n_near_x, n_near_y;

    logic                       r6_v;
    logic signed [N-1:0]        r6_near_x, r6_near_y;
    t_where                     r6_code;
    logic signed [DIFF_W-1:0]   r6_rx, r6_ry;

    logic                       r7_v;
    logic signed [N-1:0]        r7_near_x, r7_near_y;
    t_where                     r7_code;
    logic signed [2*DIFF_W-1:0] r7_sx, r7_sy;

    logic sq_v [N+2];
    t_sqr sq_d [N+2];
    t_sqr n8;

    always_comb begin
        dq    = div_d[N];
        qs_x  = $signed({1'b0, dq.quo_x});
        qs_y  = $signed({1'b0, dq.quo_y});
        sum_x = DIFF_W'(dq.pts.seg_start_x) + (dq.neg_x ? -qs_x : qs_x);
        sum_y = DIFF_W'(dq.pts.seg_start_y) + (dq.neg_y ? -qs_y : qs_y);
        case (dq.code)
            WHERE_INTERIOR: begin
                n_near_x = sum_x[N-1:0];
                n_near_y = sum_y[N-1:0];
            end
            WHERE_END: begin
                n_near_x = dq.pts.seg_end_x;
                n_near_y = dq.pts.seg_end_y;
            end
            default: begin
                n_near_x = dq.pts.seg_start_x;
                n_near_y = dq.pts.seg_start_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v     <= 1'b0;
            r7_v     <= 1'b0;
            sq_v[0]  <= 1'b0;
        end else if (en) begin
            r6_v     <= div_v[N];
            r7_v     <= r6_v;
            sq_v[0]  <= r7_v;
        end
    end

    always_comb begin
        n8.near_x = r7_near_x;
        n8.near_y = r7_near_y;
        n8.code   = r7_code;
        n8.rad    = SQ_W'($unsigned(r7_sx)) + SQ_W'($unsigned(r7_sy));
        n8.root   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_near_x <= n_near_x;
            r6_near_y <= n_near_y;
            r6_code   <= dq.code;
            r6_rx     <= DIFF_W'(dq.pts.query_x) - DIFF_W'(n_near_x);
            r6_ry     <= DIFF_W'(dq.pts.query_y) - DIFF_W'(n_near_y);

            r7_near_x <= r6_near_x;
            r7_near_y <= r6_near_y;
            r7_code   <= r6_code;
            r7_sx     <= r6_rx * r6_rx;
            r7_sy     <= r6_ry * r6_ry;

            sq_d[0]   <= n8;
        end
    end

    for (genvar g = 0; g <= N; g++) begin : g_sqrt
        psd_sqrt_stage #(
            .K (N - g)
        ) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_v[N+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.near_x     <= sq_d[N+1].near_x;
            r_out.near_y     <= sq_d[N+1].near_y;
            r_out.distance   <= sq_d[N+1].root;
            r_out.where_code <= sq_d[N+1].code;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ===== verif/point_segment_distance_tb.sv =====
// ============================================================================
// point_segment_distance_tb
// Drives segment/query transactions through the pipeline with random gaps and
// output stalls, predicts closest point, distance and code with wide integer
// arithmetic, and compares every result in order.
// ============================================================================
module point_segment_distance_tb;
    import psd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    t_out expected_q[$];
    int   n_fail;
    int   stall_cnt;

    point_segment_distance DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Floor square root of a non-negative value, bit by bit.
    function automatic logic [DIST_W-1:0] floor_root(input logic [SQ_W:0] rad);
        logic [DIST_W-1:0] res;
        logic [DIST_W-1:0] cand;
        res = '0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            cand = res | (33'd1 << b);
            if ({67'd0, cand} * {67'd0, cand} <= {34'd0, rad})
                res = cand;
        end
        return res;
    endfunction

    function automatic t_out closest_point(input t_in it);
        logic signed [127:0] sx, sy, ex, ey, px, py, dx, dy, qx, qy;
        logic signed [127:0] l2, dot, prod, ox, oy, nx, ny, rx, ry, sq;
        t_out r;
        sx = it.seg_start_x; sy = it.seg_start_y;
        ex = it.seg_end_x;   ey = it.seg_end_y;
        px = it.query_x;     py = it.query_y;
        dx = ex - sx; dy = ey - sy;
        qx = px - sx; qy = py - sy;
        l2  = dx * dx + dy * dy;
        dot = qx * dx + qy * dy;
        if (l2 == 0) begin
            nx = sx; ny = sy; r.where_code = WHERE_DEGEN;
        end else if (dot < 0) begin
            nx = sx; ny = sy; r.where_code = WHERE_START;
        end else if (dot > l2) begin
            nx = ex; ny = ey; r.where_code = WHERE_END;
        end else begin
            // Signed division in SV truncates toward zero.
            prod = dot * dx; ox = prod / l2;
            prod = dot * dy; oy = prod / l2;
            nx = sx + ox; ny = sy + oy;
            r.where_code = WHERE_INTERIOR;
        end
        rx = px - nx; ry = py - ny;
        sq = rx * rx + ry * ry;
        r.near_x   = nx[COORD_BITS-1:0];
        r.near_y   = ny[COORD_BITS-1:0];
        r.distance = floor_root(sq[SQ_W:0]);
        return r;
    endfunction

    task automatic send_query(input t_in it);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.insert(expected_q.size(), closest_point(it));
    endtask

    task automatic send_points(input logic [31:0] a, b, c, d, e, f);
        t_in it;
        it.seg_start_x = a; it.seg_start_y = b;
        it.seg_end_x   = c; it.seg_end_y   = d;
        it.query_x     = e; it.query_y     = f;
        send_query(it);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
        send_points(mn, mn, mx, mx, mx, mn);
        send_points(mx, mx, mn, mn, mn, mx);
        send_points(mn, mx, mx, mn, mn, mn);
        send_points(mn, mn, mx, mx, mn, mn);
        send_points(mn, mn, mx, mx, mx, mx);
        send_points(mx, mx, mx, mx, mn, mn);
        send_points(mn, mn, mn, mn, mx, mx);
        send_points(0, 0, 0, 0, 0, 0);
        send_points('1, '1, '1, '1, '1, '1);
    endtask

    task automatic test_codes();
        // interior, before start, past end, degenerate
        send_points(0, 0, 32'h000A_0000, 0, 32'h0003_8000, 32'h0002_0000);
        send_points(0, 0, 32'h000A_0000, 0, 32'hFFFF_0000, 32'h0001_0000);
        send_points(0, 0, 32'h000A_0000, 0, 32'h000B_0000, 32'hFFFF_0000);
        send_points(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                    32'h0004_0000, 32'h0006_0000);
        // projection exactly on start, exactly on end
        send_points(0, 0, 32'h000A_0000, 0, 0, 32'h0005_0000);
        send_points(0, 0, 32'h000A_0000, 0, 32'h000A_0000, 32'hFFFB_0000);
        // truncation toward zero with negative offsets
        send_points(32'h0000_0007, 0, 32'hFFFF_FFF9, 32'h0000_0003, 32'h0000_0001, 5);
        send_points(0, 0, 32'hFFFF_FFFD, 32'hFFFF_FFF9, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_points(5, 5, 6, 7, 5, 6);
    endtask

    task automatic test_random(input int count);
        t_in it;
        int mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 3) ? 0 : (mode < 4) ? 1 : 2;
            it.seg_start_x = rand_coord(mode); it.seg_start_y = rand_coord(mode);
            it.seg_end_x   = rand_coord(mode); it.seg_end_y   = rand_coord(mode);
            it.query_x     = rand_coord(mode); it.query_y     = rand_coord(mode);
            if ($urandom_range(0, 15) == 0) begin
                it.seg_end_x = it.seg_start_x; it.seg_end_y = it.seg_start_y;
            end
            send_query(it);
        end
    endtask

    // Output side: random stalls after each accepted result,
    // in-order compare.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result near_x=%h", o_data.near_x);
                    n_fail++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_data.near_x !== exp_r.near_x) begin
                        $error("near_x exp %h got %h", exp_r.near_x, o_data.near_x);
                        n_fail++;
                    end
                    if (o_data.near_y !== exp_r.near_y) begin
                        $error("near_y exp %h got %h", exp_r.near_y, o_data.near_y);
                        n_fail++;
                    end
                    if (o_data.distance !== exp_r.distance) begin
                        $error("distance exp %h got %h", exp_r.distance, o_data.distance);
                        n_fail++;
                    end
                    if (o_data.where_code !== exp_r.where_code) begin
                        $error("where_code exp %0d got %0d", exp_r.where_code,
                               o_data.where_code);
                        n_fail++;
                    end
                end
                stall_cnt = $urandom_range(0, 5);
            end else if (stall_cnt > 0) begin
                stall_cnt--;
            end
            i_stall <= (stall_cnt != 0);
        end
    end

    initial begin
        #8_000_000;
        $display("[point_segment_distance] ERROR");
        $finish;
    end

    initial begin
        n_fail    = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_data    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_codes();
        test_random(1100);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[point_segment_distance] OK");
        end else begin
            $display("[point_segment_distance] ERROR");
        end
        $finish;
    end
endmodule
